// ===== hw/rtl/mru_dedup_history_table_macros.svh =====
// ---------------------------------------------------------------------------
// mru_dedup_history_table_macros: assertion helpers
// Clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef MRU_DEDUP_HISTORY_TABLE_MACROS_SVH
`define MRU_DEDUP_HISTORY_TABLE_MACROS_SVH

// Same-cycle implication.
`define MDH_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mdh: same-cycle check failed");

// Next-cycle implication.
`define MDH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mdh: next-cycle check failed");

`endif

// ===== hw/rtl/mdh_pkg.sv =====
// ---------------------------------------------------------------------------
// mdh_pkg: shared types and codes
// Beat layouts, request and status codes, and the cell command.
// ---------------------------------------------------------------------------
`default_nettype none

package mdh_pkg;

	localparam int TAG_W    = 64;
	localparam int LEN_W    = 17;
	localparam int REQ_W    = 3;
	localparam int IDX_W    = 5;
	localparam int CNT_W    = 6;
	localparam int ST_W     = 2;
	// Cell bound covers every position up to the largest supported depth.
	localparam int BOUND_W  = 6;
	localparam int LIST_MAX = 32;

	localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PROMOTE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FORGET  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;
	localparam logic [REQ_W-1:0] REQ_LIST    = 3'd5;

	localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
	localparam logic [ST_W-1:0] ST_NOCHG = 2'd1;
	localparam logic [ST_W-1:0] ST_BAD   = 2'd2;

	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_DN   = 2'd1;
	localparam logic [1:0] OP_UP   = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [TAG_W-1:0] content_tag;
		logic [LEN_W-1:0] content_length;
		logic [IDX_W-1:0] slot_index;
	} mdh_req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] result_position;
		logic [TAG_W-1:0] result_tag;
		logic [LEN_W-1:0] result_length;
		logic [CNT_W-1:0] entry_count;
		logic             evicted;
		logic             last_of_run;
	} mdh_rsp_t;

	// DN: cells at or above bound load from the upper neighbor.
	// UP: cells at or below bound (from the top) load from the lower neighbor.
	typedef struct packed {
		logic [1:0]         op;
		logic [BOUND_W-1:0] bound;
	} mdh_cmd_t;

	typedef struct packed {
		logic top_hit;
		logic low_hit;
	} mdh_find_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mdh_cell.sv =====
// ---------------------------------------------------------------------------
// mdh_cell: one history entry
// Holds a tag and length, compares them with the key, and shifts toward
// or away from the top on command.
// ---------------------------------------------------------------------------
`default_nettype none

module mdh_cell import mdh_pkg::*; #(
	parameter int TW  = 64,
	parameter int IDX = 0
) (
	input  wire logic             clk,
	input  wire mdh_cmd_t         cmd,
	input  wire logic [TW-1:0]    key_tag,
	input  wire logic [LEN_W-1:0] key_len,
	input  wire logic [TW-1:0]    left_tag,
	input  wire logic [LEN_W-1:0] left_len,
	input  wire logic [TW-1:0]    right_tag,
	input  wire logic [LEN_W-1:0] right_len,
	output logic      [TW-1:0]    tag,
	output logic      [LEN_W-1:0] len,
	output logic                  match
);

	localparam logic [BOUND_W:0] MY_IDX = (BOUND_W+1)'(IDX);

	logic [TW-1:0]    tag_q;
	logic [LEN_W-1:0] len_q;
	logic             match_q;
	logic [BOUND_W:0] bound;

	assign bound = {1'b0, cmd.bound};

	// Shift the entry or hold it.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DN: begin
				if (MY_IDX <= bound) begin
					tag_q <= left_tag;
					len_q <= left_len;
				end
			end
			OP_UP: begin
				if (MY_IDX >= bound) begin
					tag_q <= right_tag;
					len_q <= right_len;
				end
			end
			default: begin
			end
		endcase
	end

	// Register the content compare.
	always_ff @(posedge clk) begin
		match_q <= (tag_q == key_tag) && (len_q == key_len);
	end

	assign tag   = tag_q;
	assign len   = len_q;
	assign match = match_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mdh_chain.sv =====
// ---------------------------------------------------------------------------
// mdh_chain: row of history cells
// Wires the cells neighbor to neighbor, picks the first lower match and
// gathers one entry by position into a register.
// ---------------------------------------------------------------------------
`default_nettype none

module mdh_chain import mdh_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int TW    = 64
) (
	input  wire logic                         clk,
	input  wire mdh_cmd_t                     cmd,
	input  wire logic [TW-1:0]                key_tag,
	input  wire logic [LEN_W-1:0]             key_len,
	input  wire logic [TW-1:0]                top_tag,
	input  wire logic [LEN_W-1:0]             top_len,
	input  wire logic [$clog2(DEPTH+1)-1:0]   fill,
	input  wire logic [$clog2(DEPTH)-1:0]     rd_pos,
	output logic      [TW-1:0]                rd_tag,
	output logic      [LEN_W-1:0]             rd_len,
	output mdh_find_t                         find,
	output logic      [$clog2(DEPTH)-1:0]     low_pos
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [TW-1:0]    tag_a [DEPTH];
	logic [LEN_W-1:0] len_a [DEPTH];
	logic [DEPTH-1:0] match;

	logic [DEPTH-1:0] low;
	logic [DEPTH-1:0] first_oh;
	logic [PW-1:0]    pos;
	logic [TW-1:0]    gat_tag;
	logic [LEN_W-1:0] gat_len;

	mdh_find_t        find_q;
	logic [PW-1:0]    pos_q;
	logic [TW-1:0]    rd_tag_q;
	logic [LEN_W-1:0] rd_len_q;

	// Build the row; the top cell takes the new entry, the last one its own.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [TW-1:0]    l_tag, r_tag;
		logic [LEN_W-1:0] l_len, r_len;

		if (g == 0) begin : g_top
			assign l_tag = top_tag;
			assign l_len = top_len;
		end else begin : g_mid
			assign l_tag = tag_a[g-1];
			assign l_len = len_a[g-1];
		end

		if (g == DEPTH-1) begin : g_end
			assign r_tag = tag_a[g];
			assign r_len = len_a[g];
		end else begin : g_nxt
			assign r_tag = tag_a[g+1];
			assign r_len = len_a[g+1];
		end

		mdh_cell #(
			.TW  (TW),
			.IDX (g)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.key_tag   (key_tag),
			.key_len   (key_len),
			.left_tag  (l_tag),
			.left_len  (l_len),
			.right_tag (r_tag),
			.right_len (r_len),
			.tag       (tag_a[g]),
			.len       (len_a[g]),
			.match     (match[g])
		);
	end

	// Isolate the first held match below the top and encode its position.
	always_comb begin
		low = '0;
		for (int j = 1; j < DEPTH; j++) begin
			low[j] = match[j] && (CW'(j) < fill);
		end
		first_oh = low & (~low + DEPTH'(1));
		pos = '0;
		for (int j = 0; j < DEPTH; j++) begin
			if (first_oh[j]) begin
				pos = pos | PW'(j);
			end
		end
	end

	// Gather the addressed entry.
	always_comb begin
		gat_tag = '0;
		gat_len = '0;
		for (int j = 0; j < DEPTH; j++) begin
			if (rd_pos == PW'(j)) begin
				gat_tag = gat_tag | tag_a[j];
				gat_len = gat_len | len_a[j];
			end
		end
	end

	// Register the pick and the gathered entry.
	always_ff @(posedge clk) begin
		find_q.top_hit <= match[0] && (fill != '0);
		find_q.low_hit <= |low;
		pos_q          <= pos;
		rd_tag_q       <= gat_tag;
		rd_len_q       <= gat_len;
	end

	assign find    = find_q;
	assign low_pos = pos_q;
	assign rd_tag  = rd_tag_q;
	assign rd_len  = rd_len_q;

endmodule

`default_nettype wire

// ===== hw/rtl/mru_dedup_history_table.sv =====
// ---------------------------------------------------------------------------
// mru_dedup_history_table: most-recent-first history with dedup
// Push, promote, forget, read, list and clear over a row of entry cells.
// ---------------------------------------------------------------------------
//
//   channel  | valid      | stall      | beat
//   ---------+------------+------------+-----------------------
//   request  | req_valid  | req_stall  | req_data  (mdh_req_t)
//   response | rsp_valid  | rsp_stall  | rsp_data  (mdh_rsp_t)
//
// A request passes through accept, cell compare, first-match pick and apply;
// one request is in work at a time. A list then walks the entries, each
// through the gather register and then the beat, as the output frees.
// The compare register in each cell and the registered pick give the compare and pick steps.
// arst_n empties the table; entry contents are not cleared.
// A stalled response holds in the output register; the next request is
// still accepted and waits in apply until that register frees.
`default_nettype none

`include "mru_dedup_history_table_macros.svh"

module mru_dedup_history_table import mdh_pkg::*; #(
	parameter int DEPTH      = 32,
	parameter int MAX_LENGTH = 65536,
	parameter int TAG_BITS   = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire mdh_req_t req_data,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output mdh_rsp_t      rsp_data
);

	localparam int PW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH+1);
	localparam int WW      = (CW > IDX_W) ? CW : IDX_W;
	localparam int NW      = WW + 1;
	localparam int LEN_ALL = (2 ** LEN_W) - 1;
	localparam logic [LEN_W-1:0] LEN_CAP =
		LEN_W'((MAX_LENGTH > LEN_ALL) ? LEN_ALL : MAX_LENGTH);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_FIND  = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_LRD   = 3'd4;
	localparam logic [2:0] S_LWR   = 3'd5;

	logic [2:0]          state_q, state_nx;
	logic [CW-1:0]       fill_q, fill_nx;
	logic [IDX_W-1:0]    ctr_q;
	logic                ctr_clr, ctr_inc;
	logic                rsp_valid_q;
	mdh_rsp_t            rsp_q, rsp_nx;
	logic                emit, fire;

	logic [REQ_W-1:0]    rtype_q;
	logic [TAG_BITS-1:0] ktag_q;
	logic [LEN_W-1:0]    klen_q;
	logic [IDX_W-1:0]    idx_q;

	mdh_cmd_t            cmd;
	logic [TAG_BITS-1:0] top_tag;
	logic [LEN_W-1:0]    top_len;
	logic [PW-1:0]       rd_pos;
	logic [TAG_BITS-1:0] rd_tag;
	logic [LEN_W-1:0]    rd_len;
	mdh_find_t           find;
	logic [PW-1:0]       low_pos;

	logic                bad;
	logic                full;
	logic [NW-1:0]       n_list;
	logic                list_last;

	mdh_chain #(
		.DEPTH (DEPTH),
		.TW    (TAG_BITS)
	) u_chain (
		.clk     (clk),
		.cmd     (cmd),
		.key_tag (ktag_q),
		.key_len (klen_q),
		.top_tag (top_tag),
		.top_len (top_len),
		.fill    (fill_q),
		.rd_pos  (rd_pos),
		.rd_tag  (rd_tag),
		.rd_len  (rd_len),
		.find    (find),
		.low_pos (low_pos)
	);

	assign req_stall = (state_q != S_IDLE);
	assign fire      = !rsp_valid_q || !rsp_stall;
	assign rd_pos    = (state_q == S_LRD || state_q == S_LWR) ? PW'(ctr_q) : PW'(idx_q);
	assign bad       = WW'(idx_q) >= WW'(fill_q);
	assign full      = fill_q >= CW'(DEPTH);
	assign n_list    = (NW'(fill_q) > NW'(LIST_MAX)) ? NW'(LIST_MAX) : NW'(fill_q);
	assign list_last = (NW'(ctr_q) + NW'(1)) == n_list;

	// Capture the request; mask the tag and saturate the length.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			rtype_q <= req_data.req_type;
			ktag_q  <= req_data.content_tag[TAG_BITS-1:0];
			klen_q  <= (req_data.content_length > LEN_CAP) ? LEN_CAP
			                                               : req_data.content_length;
			idx_q   <= req_data.slot_index;
		end
	end

	// Sequence the request and build the result beat.
	always_comb begin
		state_nx  = state_q;
		fill_nx   = fill_q;
		cmd       = '{op: OP_HOLD, bound: '0};
		top_tag   = ktag_q;
		top_len   = klen_q;
		emit      = 1'b0;
		ctr_clr   = 1'b0;
		ctr_inc   = 1'b0;
		rsp_nx    = '0;
		rsp_nx.status      = ST_DONE;
		rsp_nx.last_of_run = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nx = S_LOOK;
				end
			end
			S_LOOK: begin
				state_nx = S_FIND;
			end
			S_FIND: begin
				state_nx = S_APPLY;
			end
			S_APPLY: begin
				if (fire) begin
					state_nx = S_IDLE;
					emit     = 1'b1;
					case (rtype_q)
						REQ_PUSH: begin
							if (klen_q == '0) begin
								rsp_nx.status = ST_NOCHG;
							end else begin
								rsp_nx.result_tag    = TAG_W'(ktag_q);
								rsp_nx.result_length = klen_q;
								if (find.top_hit) begin
									rsp_nx.status = ST_NOCHG;
								end else if (find.low_hit) begin
									cmd.op                 = OP_DN;
									cmd.bound              = BOUND_W'(low_pos);
									rsp_nx.result_position = IDX_W'(low_pos);
								end else begin
									cmd.op         = OP_DN;
									cmd.bound      = full ? BOUND_W'(DEPTH-1) : BOUND_W'(fill_q);
									fill_nx        = full ? CW'(DEPTH) : fill_q + CW'(1);
									rsp_nx.evicted = full;
								end
							end
						end
						REQ_PROMOTE, REQ_FORGET, REQ_READ: begin
							rsp_nx.result_position = idx_q;
							if (bad) begin
								rsp_nx.status = ST_BAD;
							end else begin
								rsp_nx.result_tag    = TAG_W'(rd_tag);
								rsp_nx.result_length = rd_len;
								if (rtype_q == REQ_PROMOTE) begin
									if (idx_q == '0) begin
										rsp_nx.status = ST_NOCHG;
									end else begin
										cmd.op    = OP_DN;
										cmd.bound = BOUND_W'(idx_q);
										top_tag   = rd_tag;
										top_len   = rd_len;
									end
								end else if (rtype_q == REQ_FORGET) begin
									cmd.op    = OP_UP;
									cmd.bound = BOUND_W'(idx_q);
									fill_nx   = fill_q - CW'(1);
								end
							end
						end
						REQ_CLEAR: begin
							fill_nx = '0;
						end
						REQ_LIST: begin
							if (fill_q == '0) begin
								rsp_nx.status = ST_NOCHG;
							end else begin
								emit     = 1'b0;
								ctr_clr  = 1'b1;
								state_nx = S_LRD;
							end
						end
						default: begin
							rsp_nx.status = ST_NOCHG;
						end
					endcase
				end
			end
			S_LRD: begin
				state_nx = S_LWR;
			end
			S_LWR: begin
				if (fire) begin
					emit                   = 1'b1;
					rsp_nx.result_position = ctr_q;
					rsp_nx.result_tag      = TAG_W'(rd_tag);
					rsp_nx.result_length   = rd_len;
					rsp_nx.last_of_run     = list_last;
					if (list_last) begin
						state_nx = S_IDLE;
					end else begin
						ctr_inc  = 1'b1;
						state_nx = S_LRD;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase

		rsp_nx.entry_count = CNT_W'(fill_nx);
	end

	// Advance control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			ctr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			fill_q  <= fill_nx;
			if (ctr_clr) begin
				ctr_q <= '0;
			end else if (ctr_inc) begin
				ctr_q <= ctr_q + IDX_W'(1);
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register on each result beat.
	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_nx;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// Checks on count, list walk and result codes.
	`MDH_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CW'(DEPTH))
	`MDH_ASSERT_NEXT(a_fill_only_apply, state_q != S_APPLY, $stable(fill_q))
	`MDH_ASSERT_IMPL(a_list_in_range, state_q == S_LWR, NW'(ctr_q) < NW'(fill_q))
	`MDH_ASSERT_IMPL(a_evict_full, rsp_valid && rsp_data.evicted, rsp_data.entry_count == CNT_W'(DEPTH))
	`MDH_ASSERT_IMPL(a_bad_idx, rsp_valid && rsp_data.status == ST_BAD, WW'(rsp_data.result_position) >= WW'(rsp_data.entry_count))

endmodule

`default_nettype wire
